### src/mpid_pkg.sv
package mpid_pkg;

    // Width of every operand field and of the result on the ports
    localparam int FIELD_W = 32;
    // Default internal word width; operands are cut to this many low bits
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int OP_W = 2;

    // Operation codes; the fourth code gives a zero result
    localparam logic [OP_W-1:0] OP_POWER   = 2'd0;
    localparam logic [OP_W-1:0] OP_INVERSE = 2'd1;
    localparam logic [OP_W-1:0] OP_DIVIDE  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    // Operand pairing for one modular multiply
    typedef enum logic [1:0] {
        SEL_REDUCE,  // 1 * base        -> base mod m
        SEL_MULT,    // sq * acc
        SEL_SQUARE,  // sq * sq
        SEL_FINAL    // inverse * dividend
    } mpid_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_ACC,
        RES_PROD
    } mpid_res_src_t;

    typedef struct packed {
        logic          load;
        logic          start;
        mpid_sel_t     sel;
        logic          wr_sq;
        logic          wr_acc;
        logic          shift_exp;
        logic          wr_res;
        mpid_res_src_t res_src;
    } mpid_cmd_t;

    typedef struct packed {
        logic            mul_done;
        logic            exp_bit;
        logic            exp_zero;
        logic            mod_small;
        logic [OP_W-1:0] op;
    } mpid_status_t;

endpackage

### src/mpid_mulmod.sv
module mpid_mulmod #(
    parameter int WORD_BITS = mpid_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] x,     // must be below m
    input  logic [WORD_BITS-1:0] y,     // any value
    input  logic [WORD_BITS-1:0] m,
    output logic                 done,
    output logic [WORD_BITS-1:0] prod   // x*y mod m, valid from done on
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W);

    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W+1:0]  t;
    logic [W+1:0]  m1;
    logic [W+1:0]  m2;
    logic [W+1:0]  sub;

    // Interleaved multiply, top bit of y first: acc = 2*acc + y_i*x stays below 3m
    always_comb begin
        t   = {1'b0, acc_reg, 1'b0} + (y_reg[W-1] ? (W+2)'(x_reg) : '0);
        m1  = (W+2)'(m);
        m2  = {1'b0, m, 1'b0};
        if (t >= m2) begin
            sub = m2;
        end else if (t >= m1) begin
            sub = m1;
        end else begin
            sub = '0;
        end
        acc_next = W'(t - sub);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            acc_reg <= '0;
            x_reg   <= x;
            y_reg   <= y;
            cnt_reg <= CW'(W - 1);
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### src/mpid_datapath.sv
module mpid_datapath #(
    parameter int WORD_BITS = mpid_pkg::WORD_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mpid_pkg::mpid_cmd_t           cmd,
    input  logic [mpid_pkg::OP_W-1:0]     operation,
    input  logic [mpid_pkg::FIELD_W-1:0]  operand_a,
    input  logic [mpid_pkg::FIELD_W-1:0]  operand_b,
    input  logic [mpid_pkg::FIELD_W-1:0]  modulus,
    output mpid_pkg::mpid_status_t        status,
    output logic [mpid_pkg::FIELD_W-1:0]  result
);

    localparam int W  = WORD_BITS;
    localparam int FW = mpid_pkg::FIELD_W;

    logic [mpid_pkg::OP_W-1:0] op_reg;
    logic [W-1:0] m_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] base_reg;
    logic [W-1:0] exp_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] sq_reg;
    logic [FW-1:0] res_reg;

    logic [W-1:0] in_a, in_b, in_m;
    logic [W-1:0] mul_x, mul_y, prod;
    logic         mul_done;

    assign in_a = operand_a[W-1:0];
    assign in_b = operand_b[W-1:0];
    assign in_m = modulus[W-1:0];

    always_comb begin
        case (cmd.sel)
            mpid_pkg::SEL_REDUCE: begin
                mul_x = W'(1);
                mul_y = base_reg;
            end
            mpid_pkg::SEL_MULT: begin
                mul_x = sq_reg;
                mul_y = acc_reg;
            end
            mpid_pkg::SEL_SQUARE: begin
                mul_x = sq_reg;
                mul_y = sq_reg;
            end
            mpid_pkg::SEL_FINAL: begin
                mul_x = acc_reg;
                mul_y = a_reg;
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    mpid_mulmod #(
        .WORD_BITS(W)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .x       (mul_x),
        .y       (mul_y),
        .m       (m_reg),
        .done    (mul_done),
        .prod    (prod)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= operation;
            m_reg    <= in_m;
            a_reg    <= in_a;
            base_reg <= (operation == mpid_pkg::OP_DIVIDE) ? in_b : in_a;
            // Fermat exponent m-2 for inverse and divide
            exp_reg  <= (operation == mpid_pkg::OP_POWER) ? in_b : in_m - W'(2);
            acc_reg  <= W'(1);
        end else begin
            if (cmd.wr_acc) begin
                acc_reg <= prod;
            end
            if (cmd.shift_exp) begin
                exp_reg <= exp_reg >> 1;
            end
        end
        if (cmd.wr_sq) begin
            sq_reg <= prod;
        end
        if (cmd.wr_res) begin
            case (cmd.res_src)
                mpid_pkg::RES_ZERO: res_reg <= '0;
                mpid_pkg::RES_ACC:  res_reg <= FW'(acc_reg);
                mpid_pkg::RES_PROD: res_reg <= FW'(prod);
                default:            res_reg <= '0;
            endcase
        end
    end

    assign status = '{
        mul_done:  mul_done,
        exp_bit:   exp_reg[0],
        exp_zero:  (exp_reg == '0),
        mod_small: (m_reg[W-1:1] == '0),
        op:        op_reg
    };
    assign result = res_reg;

endmodule

### src/mpid_ctrl.sv
module mpid_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  mpid_pkg::mpid_status_t status,
    output mpid_pkg::mpid_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_BIT,
        ST_MULT,
        ST_SQUARE,
        ST_FINAL,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = mpid_pkg::SEL_REDUCE;
        cmd.res_src = mpid_pkg::RES_ZERO;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.mod_small || status.op == mpid_pkg::OP_UNUSED) begin
                    cmd.wr_res  = 1'b1;
                    cmd.res_src = mpid_pkg::RES_ZERO;
                    state_next  = ST_OUT;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.sel    = mpid_pkg::SEL_REDUCE;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (status.mul_done) begin
                    cmd.wr_sq  = 1'b1;
                    state_next = ST_BIT;
                end
            end
            ST_BIT: begin
                if (status.exp_zero) begin
                    if (status.op == mpid_pkg::OP_DIVIDE) begin
                        cmd.start  = 1'b1;
                        cmd.sel    = mpid_pkg::SEL_FINAL;
                        state_next = ST_FINAL;
                    end else begin
                        cmd.wr_res  = 1'b1;
                        cmd.res_src = mpid_pkg::RES_ACC;
                        state_next  = ST_OUT;
                    end
                end else if (status.exp_bit) begin
                    cmd.start  = 1'b1;
                    cmd.sel    = mpid_pkg::SEL_MULT;
                    state_next = ST_MULT;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.sel    = mpid_pkg::SEL_SQUARE;
                    state_next = ST_SQUARE;
                end
            end
            ST_MULT: begin
                // chain the square straight after the multiply
                if (status.mul_done) begin
                    cmd.wr_acc = 1'b1;
                    cmd.start  = 1'b1;
                    cmd.sel    = mpid_pkg::SEL_SQUARE;
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (status.mul_done) begin
                    cmd.wr_sq     = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = ST_BIT;
                end
            end
            ST_FINAL: begin
                if (status.mul_done) begin
                    cmd.wr_res  = 1'b1;
                    cmd.res_src = mpid_pkg::RES_PROD;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/modular_power_inverse_divide.sv
// Modular power, Fermat inverse and modular divide on one item at a time. Each input item
// carries an operation (power a^b, inverse a^(m-2), divide a*b^(m-2)), two operands and a
// modulus, and gives one result in 0..m-1; a modulus below two or the unused operation code
// gives 0. Inverse and divide assume a prime modulus. All arithmetic runs on one shared
// modular multiplier that retires one multiplier bit per cycle. After a reduction of the
// base, each exponent bit up to the highest set one costs a square, and each set bit also a
// multiply (the exponent is b for power, m-2 otherwise); divide adds one more multiply. The
// block takes a new item only after the previous result has been taken.
module modular_power_inverse_divide #(
    parameter int WORD_BITS = mpid_pkg::WORD_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // operand_a [31:0], operand_b [63:32], modulus [95:64]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result [31:0]
);

    localparam int FW = mpid_pkg::FIELD_W;

    mpid_pkg::mpid_cmd_t    cmd;
    mpid_pkg::mpid_status_t status;

    mpid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mpid_datapath #(
        .WORD_BITS(WORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .operation (s_tuser),
        .operand_a (s_tdata[FW-1:0]),
        .operand_b (s_tdata[2*FW-1:FW]),
        .modulus   (s_tdata[3*FW-1:2*FW]),
        .status    (status),
        .result    (m_tdata)
    );

endmodule

### src/mpid_checker.sv
module mpid_assertions (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // one item in flight: never ready for input while a result is shown
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // a result never appears in the cycle after an item is taken
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result shown right after accept");

    // after a result is taken, the block is ready again
    a_back_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
        else $error("not ready after result was taken");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind modular_power_inverse_divide mpid_assertions u_mpid_checker (.*);

### bench/mpid_checker.sv
`timescale 1ns / 1ps

module mpid_checker #(
    parameter int WORD_BITS = mpid_pkg::WORD_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // operand_a [31:0], operand_b [63:32], modulus [95:64]
    input  logic [1:0]  s_tuser,   // operation [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // result [31:0]
    output int          failures,
    output int          outstanding
);

    logic [31:0] residues_due[$];
    logic [31:0] want;

    // Right-to-left square-and-multiply over WORD_BITS exponent bits
    function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] expo,
                                              logic [63:0] m);
        logic [63:0] acc;
        logic [63:0] sq;
        int          i;
        acc = 64'd1 % m;
        sq = base % m;
        for (i = 0; i < WORD_BITS; i++) begin
            if (expo[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc;
    endfunction

    function automatic logic [31:0] predict_residue(logic [1:0] op, logic [31:0] a_in,
                                                    logic [31:0] b_in, logic [31:0] m_in);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] m;
        logic [63:0] r;
        mask = (64'd1 << WORD_BITS) - 64'd1;
        a = {32'd0, a_in} & mask;
        b = {32'd0, b_in} & mask;
        m = {32'd0, m_in} & mask;
        r = 64'd0;
        if (m >= 64'd2) begin
            case (op)
                mpid_pkg::OP_POWER:   r = power_mod(a, b, m);
                mpid_pkg::OP_INVERSE: r = power_mod(a, m - 64'd2, m);
                mpid_pkg::OP_DIVIDE:  r = ((a % m) * power_mod(b % m, m - 64'd2, m)) % m;
                default:              r = 64'd0;
            endcase
        end
        return r[31:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] expected, logic [31:0] got);
        $display("%0t: MISMATCH %s: expected %h, got %h", $realtime, what, expected, got);
        failures++;
    endtask

    // Retire the result before queuing a new item so a same-edge pair stays in order
    always @(posedge aclk) begin
        if (!aresetn) begin
            residues_due.delete();
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (residues_due.size() == 0) begin
                    report_mismatch("result with no item outstanding", 32'd0, m_tdata);
                end else begin
                    want = residues_due.pop_front();
                    if (m_tdata !== want)
                        report_mismatch("result", want, m_tdata);
                end
            end
            if (s_tvalid && s_tready)
                residues_due = {residues_due,
                                predict_residue(s_tuser, s_tdata[31:0],
                                                s_tdata[63:32], s_tdata[95:64])};
            outstanding <= residues_due.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_COUNT  = 270;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 2300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        steady   = 1'b0;

    int failures;
    int outstanding;
    int stall_cycles;

    logic [31:0] primes[10] = '{32'd2, 32'd3, 32'd5, 32'd7, 32'd13, 32'd65537,
                                32'd998244353, 32'd1000000007, 32'd2147483647,
                                32'd4294967291};

    always #1 aclk = ~aclk;

    modular_power_inverse_divide u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mpid_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        m_tready <= aresetn && (steady || $urandom_range(99) >= 26);
    end

    // Keep valid high across back-to-back items; drop it only for a gap
    task automatic send_item(logic [1:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] m);
        int gap;
        if (!steady && $urandom_range(99) < 26) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {m, b, a};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    function automatic logic [31:0] pick_modulus(bit want_prime);
        logic [31:0] m;
        if (want_prime && $urandom_range(99) < 70)
            return primes[4'($urandom_range(9))];
        case ($urandom_range(9))
            0, 1, 2: m = primes[4'($urandom_range(9))];
            3, 4:    m = $urandom_range(2, 255);
            5, 6:    m = $urandom;
            7:       m = {1'b1, 31'($urandom)};
            8:       m = $urandom_range(2, 65535);
            default: m = ($urandom_range(4) == 0) ? 32'($urandom_range(1)) : 32'($urandom);
        endcase
        return m;
    endfunction

    function automatic logic [31:0] pick_operand(logic [31:0] m);
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1:    v = $urandom_range(15);
            2:       v = m;
            3:       v = 32'd0;
            4:       v = m << 1;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_random();
        logic [1:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] m;
        op = ($urandom_range(19) == 0) ? mpid_pkg::OP_UNUSED : 2'($urandom_range(2));
        m = pick_modulus(op == mpid_pkg::OP_INVERSE || op == mpid_pkg::OP_DIVIDE);
        a = pick_operand(m);
        if (op == mpid_pkg::OP_POWER) begin
            case ($urandom_range(9))
                0, 1:    b = $urandom_range(3);
                2, 3, 4: b = $urandom;
                default: b = $urandom_range(1023);
            endcase
        end else begin
            b = pick_operand(m);
        end
        send_item(op, a, b, m);
    endtask

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(mpid_pkg::OP_POWER,   32'd0,        32'd0,        32'd5);
        send_item(mpid_pkg::OP_POWER,   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(mpid_pkg::OP_POWER,   32'd2,        32'd10,       32'd1000);
        send_item(mpid_pkg::OP_POWER,   32'd5,        32'd0,        32'd2);
        send_item(mpid_pkg::OP_POWER,   32'd12345,    32'd65537,    32'd4294967291);
        send_item(mpid_pkg::OP_POWER,   32'hFFFFFFFF, 32'd2,        32'd65536);
        send_item(mpid_pkg::OP_POWER,   32'd3,        32'd5,        32'd0);
        send_item(mpid_pkg::OP_POWER,   32'd3,        32'd5,        32'd1);
        send_item(mpid_pkg::OP_INVERSE, 32'd3,        32'd0,        32'd7);
        send_item(mpid_pkg::OP_INVERSE, 32'd0,        32'd9,        32'd13);
        send_item(mpid_pkg::OP_INVERSE, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd4294967291);
        send_item(mpid_pkg::OP_INVERSE, 32'd1,        32'd0,        32'd2);
        send_item(mpid_pkg::OP_INVERSE, 32'd5,        32'd0,        32'd1);
        send_item(mpid_pkg::OP_INVERSE, 32'd123456789, 32'd0,       32'd1000000007);
        send_item(mpid_pkg::OP_DIVIDE,  32'd10,       32'd4,        32'd13);
        send_item(mpid_pkg::OP_DIVIDE,  32'd7,        32'd13,       32'd13);
        send_item(mpid_pkg::OP_DIVIDE,  32'd7,        32'd0,        32'd11);
        send_item(mpid_pkg::OP_DIVIDE,  32'd5,        32'd3,        32'd2);
        send_item(mpid_pkg::OP_DIVIDE,  32'hFFFFFFFF, 32'hFFFFFFFE, 32'd4294967291);
        send_item(mpid_pkg::OP_DIVIDE,  32'd9,        32'd9,        32'd0);
        send_item(mpid_pkg::OP_UNUSED,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'd4294967291);
        send_item(mpid_pkg::OP_UNUSED,  32'd0,        32'd0,        32'd0);
        wait_drained();

        for (int n = 0; n < ITEM_COUNT; n++) begin
            // Run a stretch with no input gaps and the output always ready
            if (n == 100)
                steady <= 1'b1;
            if (n == 160)
                steady <= 1'b0;
            if (n == 200)
                wait_drained();
            send_random();
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
